// ----- rtl/core/dmpd_pkg.sv -----
// Shared types, codes and constants of the dual motor PWM drive unit.
`timescale 1ns / 1ps
`default_nettype none
package dmpd_pkg;

   // Count that means "full on" or "full off"; the result fields carry 13 bits of it.
   localparam int PWM_FULL = 4096;
   localparam logic [12:0] PWM_FULL_COUNT = 13'(PWM_FULL % 8192);

   localparam logic [11:0] PWM_MIN_RESET    = 12'd1500;
   localparam logic [11:0] PWM_MAX_RESET    = 12'd4095;
   localparam logic [6:0]  TRIM_LIMIT_RESET = 7'd30;

   localparam logic [15:0] SPEED_FULL_SCALE = 16'd100;

   // floor(x / 100) for x below 2^19 as (x * DIV100_RECIP) >> DIV100_SHIFT.
   localparam int          DIV100_SHIFT = 26;
   localparam logic [19:0] DIV100_RECIP = 20'((64'd1 << DIV100_SHIFT) / 64'd100 + 64'd1);

   localparam logic OP_SPEED = 1'b0;
   localparam logic OP_TRIM  = 1'b1;

   localparam logic [1:0] SEL_FIRST  = 2'd1;
   localparam logic [1:0] SEL_SECOND = 2'd2;

   localparam logic [1:0] CSR_PWM_MIN    = 2'd0;
   localparam logic [1:0] CSR_PWM_MAX    = 2'd1;
   localparam logic [1:0] CSR_TRIM_LIMIT = 2'd2;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_RANGE = 2'd1,
      STS_MOTOR = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CLS_OFF,
      CLS_FULL,
      CLS_PART,
      CLS_SAT
   } pwm_class_type;

   typedef struct packed {
      logic              operation;
      logic signed [7:0] speed_first;
      logic signed [7:0] speed_second;
      logic [1:0]        motor_select;
      logic signed [7:0] trim_amount;
   } req_type;

   typedef struct packed {
      logic               motor_index;
      logic               pwm_write;
      logic [12:0]        pwm_on;
      logic [12:0]        pwm_off;
      logic               dir_write;
      logic               dir_in1;
      logic               dir_in2;
      logic signed [15:0] trim_value;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   // Per-motor decisions handed from the first stage to the scaling stage.
   typedef struct packed {
      logic          pwm_write;
      pwm_class_type cls;
      logic [18:0]   product;
      logic          dir_write;
      logic          rev;
   } drive_type;

endpackage
`default_nettype wire

// ----- rtl/core/dmpd_drive.sv -----
// First-stage speed logic of one motor: trim, magnitude, class, direction.
`timescale 1ns / 1ps
`default_nettype none
module dmpd_drive (
   input  wire logic               active,
   input  wire logic signed [7:0]  speed,
   input  wire logic signed [15:0] trim,
   input  wire logic               use_trim,
   input  wire logic               rev,
   input  wire logic [11:0]        pwm_min,
   input  wire logic [11:0]        pwm_max,
   output dmpd_pkg::drive_type     drive
);
   import dmpd_pkg::*;

   logic signed [16:0] speed_ext;
   logic signed [16:0] trim_ext;
   logic signed [16:0] adjusted;
   logic [16:0]        mag_full;
   logic [15:0]        mag;
   logic               neg;
   logic               nonzero;
   logic [11:0]        diff;
   logic               inverted;

   always_comb begin
      speed_ext = $signed({{9{speed[7]}}, speed});
      trim_ext  = $signed({trim[15], trim});
      adjusted  = speed_ext;
      if (use_trim) begin
         if (speed[7]) begin
            adjusted = speed_ext + trim_ext;
         end else begin
            adjusted = speed_ext - trim_ext;
         end
      end
      neg      = adjusted[16];
      mag_full = neg ? 17'(-adjusted) : 17'(adjusted);
      mag      = mag_full[15:0];
      nonzero  = (mag != 16'd0);
      inverted = (pwm_max <= pwm_min);
      diff     = pwm_max - pwm_min;

      if (!nonzero) begin
         drive.cls = CLS_OFF;
      end else if (mag == SPEED_FULL_SCALE) begin
         drive.cls = CLS_FULL;
      end else if (mag > SPEED_FULL_SCALE || inverted) begin
         drive.cls = CLS_SAT;
      end else begin
         drive.cls = CLS_PART;
      end

      drive.product   = {7'd0, diff} * {12'd0, mag[6:0]};
      drive.pwm_write = active;
      drive.dir_write = active && ((nonzero && !neg && rev) || (neg && !rev));
      drive.rev       = drive.dir_write ? neg : rev;
   end

endmodule
`default_nettype wire

// ----- rtl/core/dmpd_trim.sv -----
// Stored motor trims and the trim request check and rebalance.
`timescale 1ns / 1ps
`default_nettype none
module dmpd_trim (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               update,
   input  wire dmpd_pkg::req_type  req_item,
   input  wire logic [6:0]         trim_limit,
   output logic signed [15:0]      trim_first,
   output logic signed [15:0]      trim_second,
   output logic signed [15:0]      trim_first_next,
   output logic signed [15:0]      trim_second_next,
   output dmpd_pkg::status_type    status
);
   import dmpd_pkg::*;

   logic signed [15:0] trim_first_ff;
   logic signed [15:0] trim_second_ff;
   logic signed [15:0] trim_first_in;
   logic signed [15:0] trim_second_in;

   logic signed [8:0]  adj_ext;
   logic [8:0]         adj_mag_full;
   logic [7:0]         adj_mag;
   logic               sel_first;
   logic               sel_ok;
   logic signed [15:0] other;
   logic signed [16:0] other_ext;
   logic signed [16:0] adj17;
   logic [16:0]        other_mag_full;
   logic [15:0]        other_mag;
   logic signed [15:0] other_new;
   logic signed [15:0] chosen_new;
   logic signed [15:0] chosen_val;
   logic signed [15:0] other_val;

   function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
      logic signed [15:0] r;
      if (v > 17'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -17'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   always_comb begin
      adj_ext        = $signed({req_item.trim_amount[7], req_item.trim_amount});
      adj_mag_full   = adj_ext[8] ? 9'(-adj_ext) : 9'(adj_ext);
      adj_mag        = adj_mag_full[7:0];
      sel_first      = (req_item.motor_select == SEL_FIRST);
      sel_ok         = sel_first || (req_item.motor_select == SEL_SECOND);
      other          = sel_first ? trim_second_ff : trim_first_ff;
      other_ext      = $signed({other[15], other});
      adj17          = $signed({{9{req_item.trim_amount[7]}}, req_item.trim_amount});
      other_mag_full = other_ext[16] ? 17'(-other_ext) : 17'(other_ext);
      other_mag      = other_mag_full[15:0];

      if (other_mag >= {8'd0, adj_mag}) begin
         chosen_new = 16'sd0;
         other_new  = sat16(other_ext - adj17);
      end else begin
         chosen_new = sat16(adj17 - other_ext);
         other_new  = 16'sd0;
      end

      chosen_val     = chosen_new;
      other_val      = other_new;
      trim_first_in  = trim_first_ff;
      trim_second_in = trim_second_ff;
      status         = STS_OK;
      if (req_item.operation == OP_TRIM) begin
         if ({1'b0, adj_mag} > {2'b00, trim_limit}) begin
            status = STS_RANGE;
         end else if (!sel_ok) begin
            status = STS_MOTOR;
         end else if (sel_first) begin
            trim_first_in  = chosen_val;
            trim_second_in = other_val;
         end else begin
            trim_second_in = chosen_val;
            trim_first_in  = other_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_first_ff  <= '0;
         trim_second_ff <= '0;
      end else if (update) begin
         trim_first_ff  <= trim_first_in;
         trim_second_ff <= trim_second_in;
      end
   end

   assign trim_first       = trim_first_ff;
   assign trim_second      = trim_second_ff;
   assign trim_first_next  = trim_first_in;
   assign trim_second_next = trim_second_in;

endmodule
`default_nettype wire

// ----- rtl/core/dmpd_scale.sv -----
// Second-stage PWM count of one motor: divide by the speed scale and select.
`timescale 1ns / 1ps
`default_nettype none
module dmpd_scale (
   input  wire dmpd_pkg::drive_type drive,
   input  wire logic [11:0]         pwm_min,
   input  wire logic [11:0]         pwm_max,
   output logic [12:0]              pwm_on,
   output logic [12:0]              pwm_off
);
   import dmpd_pkg::*;

   logic [38:0] scaled;
   logic [11:0] quotient;

   always_comb begin
      scaled   = {20'd0, drive.product} * {19'd0, DIV100_RECIP};
      quotient = scaled[DIV100_SHIFT +: 12];
      pwm_on   = 13'd0;
      pwm_off  = 13'd0;
      if (drive.pwm_write) begin
         case (drive.cls)
            CLS_OFF: begin
               pwm_off = PWM_FULL_COUNT;
            end
            CLS_FULL: begin
               pwm_on = PWM_FULL_COUNT;
            end
            CLS_SAT: begin
               pwm_off = {1'b0, pwm_max};
            end
            CLS_PART: begin
               pwm_off = {1'b0, pwm_min} + {1'b0, quotient};
            end
            default: begin
               pwm_off = 13'd0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/dmpd_pair.sv -----
// Output buffer that holds both results of an item and sends them in turn.
`timescale 1ns / 1ps
`default_nettype none
module dmpd_pair (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire dmpd_pkg::rsp_type first_item,
   input  wire dmpd_pkg::rsp_type second_item,
   output logic                   ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dmpd_pkg::rsp_type      rsp_data
);
   import dmpd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   logic    sel_ff;
   logic    sel_in;
   rsp_type first_ff;
   rsp_type second_ff;

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (valid_ff && !rsp_stall) begin
         if (sel_ff) begin
            valid_in = 1'b0;
         end else begin
            sel_in = 1'b1;
         end
      end
      if (load) begin
         valid_in = 1'b1;
         sel_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         first_ff  <= first_item;
         second_ff <= second_item;
      end
   end

   assign ready     = !valid_ff || (sel_ff && !rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = sel_ff ? second_ff : first_ff;

endmodule
`default_nettype wire

// ----- rtl/core/dual_motor_pwm_drive_unit.sv -----
// Top level of the dual motor PWM drive unit.
//
// Drives two H-bridge motors. Each item on the req_ channel either sets both
// motor speeds (signed percent) or applies a trim request to one motor. Every
// item gives exactly two results on the rsp_ channel, the first for motor 0
// and the second for motor 1 (last set), each with the PWM counts, direction
// pin levels, the motor's trim and a status code.
// An item is taken at a clock edge with valid high and stall low, on either
// channel. The csr_ port writes pwm_min, pwm_max and trim_limit at any edge
// with csr_we high; it is meant to be used only while the unit is idle.
// Pipeline: input register, a decision stage (trim adjust, magnitude,
// direction, trim update, the diff * speed product), a scaling stage that
// divides by 100 with a reciprocal multiply, and a two-entry output buffer.
// The first result is offered once the item is in the output buffer, the
// second in the cycle after the first is taken, one result per cycle while
// rsp_stall is low; the buffer loads the next item as the second is taken.
// A stalled receiver holds the current result steady; items back up through
// the pipeline and req_stall rises once the input register cannot move.
// Synchronous reset clears the trims, sets both motors forward, loads the
// register defaults (1500, 4095, 30) and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module dual_motor_pwm_drive_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire dmpd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dmpd_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [11:0]       csr_wdata
);
   import dmpd_pkg::*;

   // Configuration registers.
   logic [11:0] pwm_min_ff;
   logic [11:0] pwm_max_ff;
   logic [6:0]  trim_limit_ff;

   // Input register.
   logic    in_valid_ff;
   req_type in_item_ff;
   logic    in_ready;
   logic    in_advance;

   // Stored directions, 1 for reverse.
   logic rev_first_ff;
   logic rev_second_ff;

   // Decision stage outputs and the registers between the two stages.
   drive_type          drive_first;
   drive_type          drive_second;
   logic signed [15:0] trim_first;
   logic signed [15:0] trim_second;
   logic signed [15:0] trim_first_next;
   logic signed [15:0] trim_second_next;
   status_type         status;
   logic               is_speed;
   logic               speeds_equal;

   logic               mid_valid_ff;
   drive_type          mid_first_ff;
   drive_type          mid_second_ff;
   logic signed [15:0] mid_trim_first_ff;
   logic signed [15:0] mid_trim_second_ff;
   status_type         mid_status_ff;
   logic               mid_ready;
   logic               mid_advance;

   // Scaling stage and output buffer.
   logic [12:0] on_first;
   logic [12:0] off_first;
   logic [12:0] on_second;
   logic [12:0] off_second;
   rsp_type     result_first;
   rsp_type     result_second;
   logic        pair_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_min_ff    <= PWM_MIN_RESET;
         pwm_max_ff    <= PWM_MAX_RESET;
         trim_limit_ff <= TRIM_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PWM_MIN:    pwm_min_ff    <= csr_wdata;
            CSR_PWM_MAX:    pwm_max_ff    <= csr_wdata;
            CSR_TRIM_LIMIT: trim_limit_ff <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake chain: each stage moves when the next one is free or moving.
   assign mid_ready   = !mid_valid_ff || pair_ready;
   assign in_ready    = !in_valid_ff || mid_ready;
   assign req_stall   = !in_ready;
   assign in_advance  = in_valid_ff && mid_ready;
   assign mid_advance = mid_valid_ff && pair_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_valid;
         end
         if (mid_ready) begin
            mid_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_ready) begin
         in_item_ff <= req_data;
      end
   end

   assign is_speed     = (in_item_ff.operation == OP_SPEED);
   assign speeds_equal = (in_item_ff.speed_first == in_item_ff.speed_second);

   dmpd_trim u_trim (
      .clock            (clock),
      .reset            (reset),
      .update           (in_advance),
      .req_item         (in_item_ff),
      .trim_limit       (trim_limit_ff),
      .trim_first       (trim_first),
      .trim_second      (trim_second),
      .trim_first_next  (trim_first_next),
      .trim_second_next (trim_second_next),
      .status           (status)
   );

   // Speed items never change the trims, so the stored values apply here.
   dmpd_drive u_drive_first (
      .active   (is_speed),
      .speed    (in_item_ff.speed_first),
      .trim     (trim_first),
      .use_trim (speeds_equal),
      .rev      (rev_first_ff),
      .pwm_min  (pwm_min_ff),
      .pwm_max  (pwm_max_ff),
      .drive    (drive_first)
   );

   dmpd_drive u_drive_second (
      .active   (is_speed),
      .speed    (in_item_ff.speed_second),
      .trim     (trim_second),
      .use_trim (speeds_equal),
      .rev      (rev_second_ff),
      .pwm_min  (pwm_min_ff),
      .pwm_max  (pwm_max_ff),
      .drive    (drive_second)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_first_ff  <= 1'b0;
         rev_second_ff <= 1'b0;
      end else if (in_advance) begin
         rev_first_ff  <= drive_first.rev;
         rev_second_ff <= drive_second.rev;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         mid_first_ff       <= drive_first;
         mid_second_ff      <= drive_second;
         mid_trim_first_ff  <= trim_first_next;
         mid_trim_second_ff <= trim_second_next;
         mid_status_ff      <= status;
      end
   end

   dmpd_scale u_scale_first (
      .drive   (mid_first_ff),
      .pwm_min (pwm_min_ff),
      .pwm_max (pwm_max_ff),
      .pwm_on  (on_first),
      .pwm_off (off_first)
   );

   dmpd_scale u_scale_second (
      .drive   (mid_second_ff),
      .pwm_min (pwm_min_ff),
      .pwm_max (pwm_max_ff),
      .pwm_on  (on_second),
      .pwm_off (off_second)
   );

   always_comb begin
      result_first.motor_index = 1'b0;
      result_first.pwm_write   = mid_first_ff.pwm_write;
      result_first.pwm_on      = on_first;
      result_first.pwm_off     = off_first;
      result_first.dir_write   = mid_first_ff.dir_write;
      result_first.dir_in1     = !mid_first_ff.rev;
      result_first.dir_in2     = mid_first_ff.rev;
      result_first.trim_value  = mid_trim_first_ff;
      result_first.status      = mid_status_ff;
      result_first.last        = 1'b0;

      result_second.motor_index = 1'b1;
      result_second.pwm_write   = mid_second_ff.pwm_write;
      result_second.pwm_on      = on_second;
      result_second.pwm_off     = off_second;
      result_second.dir_write   = mid_second_ff.dir_write;
      result_second.dir_in1     = !mid_second_ff.rev;
      result_second.dir_in2     = mid_second_ff.rev;
      result_second.trim_value  = mid_trim_second_ff;
      result_second.status      = mid_status_ff;
      result_second.last        = 1'b1;
   end

   dmpd_pair u_pair (
      .clock       (clock),
      .reset       (reset),
      .load        (mid_advance),
      .first_item  (result_first),
      .second_item (result_second),
      .ready       (pair_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

// ----- rtl/core/dmpd_checker.sv -----
// Port-level checks of the dual motor PWM drive unit and their binding.
`timescale 1ns / 1ps
`default_nettype none
module dmpd_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire dmpd_pkg::rsp_type rsp_data
);
   import dmpd_pkg::*;

   // A stalled result stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // The second result of an item follows the first without a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid && rsp_data.motor_index)
      else $error("second result of an item missing");

   // Results come in motor order, the second one marked last.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.motor_index == rsp_data.last)
      else $error("motor index and last disagree");

   // Trim items leave the PWM counts and direction write quiet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.pwm_write |->
         !rsp_data.dir_write && rsp_data.pwm_on == 13'd0 && rsp_data.pwm_off == 13'd0)
      else $error("PWM fields set without a PWM write");

   // The bridge inputs always show exactly one direction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.dir_in1 != rsp_data.dir_in2)
      else $error("direction pins not complementary");

endmodule

bind dual_motor_pwm_drive_unit dmpd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
